// ----- design/clw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Line clip to window package
// Shared types, register indexes, outcode bits and the outcode function.
// ----------------------------------------------------------------------------
package clw_pkg;

  localparam int MaxPassesDef  = 8;
  localparam int CoordBitsDef  = 16;
  localparam int CfgIdxBits    = 2;
  localparam int CfgDataBits   = 9;
  localparam int CalcBits      = 33;

  localparam logic [3:0] OcLeft   = 4'd1;
  localparam logic [3:0] OcRight  = 4'd2;
  localparam logic [3:0] OcTop    = 4'd4;
  localparam logic [3:0] OcBottom = 4'd8;

  localparam logic [CfgIdxBits-1:0] CfgLeft   = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgRight  = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgTop    = 2'd2;
  localparam logic [CfgIdxBits-1:0] CfgBottom = 2'd3;

  typedef struct packed {
    logic [8:0] left_edge;
    logic [8:0] right_edge;
    logic [7:0] top_edge;
    logic [7:0] bottom_edge;
  } window_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_UPD
  } clip_state_t;

  // Coordinates arrive sign-extended to CalcBits bits.
  function automatic logic [3:0] outcode(logic signed [CalcBits-1:0] x,
                                         logic signed [CalcBits-1:0] y,
                                         window_t w);
    logic [3:0] c;
    c = 4'd0;
    if (x < $signed({24'd0, w.left_edge}))   c = c | OcLeft;
    if (x > $signed({24'd0, w.right_edge}))  c = c | OcRight;
    if (y < $signed({25'd0, w.top_edge}))    c = c | OcTop;
    if (y > $signed({25'd0, w.bottom_edge})) c = c | OcBottom;
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- design/clw_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Line clip to window queue
// Small register FIFO between the front and the clip engine.
// ----------------------------------------------------------------------------
module clw_queue #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output      logic             full,
  input  wire logic             pop,
  output      logic [WIDTH-1:0] head_data,
  output      logic             empty
);
  localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntBits = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   mem_r [DEPTH];
  logic [PtrBits-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntBits-1:0] count_r;

  assign full      = (count_r == CntBits'(DEPTH));
  assign empty     = (count_r == '0);
  assign head_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- design/clw_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Line clip to window front
// Accepts segments, computes both endpoint outcodes and hands them to the queue.
// ----------------------------------------------------------------------------
module clw_front import clw_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDef
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output      logic                    busy,
  input  wire logic [COORD_BITS-1:0]   in_first_x,
  input  wire logic [COORD_BITS-1:0]   in_first_y,
  input  wire logic [COORD_BITS-1:0]   in_second_x,
  input  wire logic [COORD_BITS-1:0]   in_second_y,
  input  wire window_t                 win,
  output      logic                    push,
  output      logic [4*COORD_BITS+7:0] push_data,
  input  wire logic                    q_full
);
  localparam int ExtBits = CalcBits - COORD_BITS;

  logic                    stage_valid_r;
  logic [4*COORD_BITS+7:0] stage_data_r;
  logic                    take;
  logic [3:0]              c1, c2;

  assign push = stage_valid_r && !q_full;
  assign busy = stage_valid_r && q_full;
  assign take = start && !busy;
  assign push_data = stage_data_r;

  assign c1 = outcode($signed({{ExtBits{in_first_x[COORD_BITS-1]}}, in_first_x}),
                      $signed({{ExtBits{in_first_y[COORD_BITS-1]}}, in_first_y}), win);
  assign c2 = outcode($signed({{ExtBits{in_second_x[COORD_BITS-1]}}, in_second_x}),
                      $signed({{ExtBits{in_second_y[COORD_BITS-1]}}, in_second_y}), win);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (take) begin
      stage_valid_r <= 1'b1;
    end else if (push) begin
      stage_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage_data_r <= {c2, c1, in_second_y, in_second_x, in_first_y, in_first_x};
    end
  end

endmodule
`default_nettype wire

// ----- design/clw_clip.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Line clip to window clip engine
// Runs the edge passes: operand setup, multiply, bit-serial divide, update.
// ----------------------------------------------------------------------------
module clw_clip import clw_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDef,
  parameter int MAX_PASSES = MaxPassesDef
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire window_t                 win,
  input  wire logic                    q_empty,
  input  wire logic [4*COORD_BITS+7:0] q_head,
  output      logic                    pop,
  output      logic                    out_valid,
  output      logic [COORD_BITS-1:0]   out_clipped_first_x,
  output      logic [COORD_BITS-1:0]   out_clipped_first_y,
  output      logic [COORD_BITS-1:0]   out_clipped_second_x,
  output      logic [COORD_BITS-1:0]   out_clipped_second_y,
  output      logic                    out_rejected
);
  localparam int C       = COORD_BITS;
  localparam int W       = COORD_BITS + 1;
  localparam int PassBits = $clog2(MAX_PASSES + 1);
  localparam int CntBits  = $clog2(W + 1);
  localparam int ExtBits  = CalcBits - COORD_BITS;

  clip_state_t state_r, state_nxt;

  logic signed [C-1:0] x1_r, y1_r, x2_r, y2_r;
  logic signed [C-1:0] x1_nxt, y1_nxt, x2_nxt, y2_nxt;
  logic [3:0]          c1_r, c2_r, c1_nxt, c2_nxt;
  logic [PassBits-1:0] pass_r, pass_nxt;
  logic                first_r, first_nxt;   // moving the first endpoint
  logic                ysel_r, ysel_nxt;     // clipping against a y edge
  logic [8:0]          edge_r, edge_nxt;
  logic signed [C-1:0] base_r, base_nxt;
  logic signed [W-1:0] delta_r, delta_nxt, num_r, num_nxt, den_r, den_nxt;
  logic [W-1:0]        divisor_r, divisor_nxt, rem_r, rem_nxt, dq_r, dq_nxt;
  logic                neg_r, neg_nxt, dz_r, dz_nxt;
  logic [CntBits-1:0]  cnt_r, cnt_nxt;

  logic                ov_r, ov_nxt, rej_r, rej_nxt;
  logic [C-1:0]        ox1_r, oy1_r, ox2_r, oy2_r, ox1_nxt, oy1_nxt, ox2_nxt, oy2_nxt;

  logic [3:0]          co;
  logic signed [C-1:0] bo, eo, bc, ec;
  logic [8:0]          edge_sel;
  logic [W-1:0]        mag_d, mag_n;
  logic [2*W-1:0]      prod;
  logic [W:0]          trial;
  logic [W-1:0]        q;
  logic signed [W-1:0] interp;
  logic signed [C-1:0] edge_c, nx, ny;
  logic [3:0]          nc;

  assign out_valid            = ov_r;
  assign out_rejected         = rej_r;
  assign out_clipped_first_x  = ox1_r;
  assign out_clipped_first_y  = oy1_r;
  assign out_clipped_second_x = ox2_r;
  assign out_clipped_second_y = oy2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x1_r <= x1_nxt;  y1_r <= y1_nxt;  x2_r <= x2_nxt;  y2_r <= y2_nxt;
    c1_r <= c1_nxt;  c2_r <= c2_nxt;  pass_r <= pass_nxt;
    first_r <= first_nxt;  ysel_r <= ysel_nxt;  edge_r <= edge_nxt;
    base_r <= base_nxt;  delta_r <= delta_nxt;  num_r <= num_nxt;  den_r <= den_nxt;
    divisor_r <= divisor_nxt;  rem_r <= rem_nxt;  dq_r <= dq_nxt;
    neg_r <= neg_nxt;  dz_r <= dz_nxt;  cnt_r <= cnt_nxt;
    rej_r <= rej_nxt;
    ox1_r <= ox1_nxt;  oy1_r <= oy1_nxt;  ox2_r <= ox2_nxt;  oy2_r <= oy2_nxt;
  end

  // Datapath pieces shared by the states.
  always_comb begin
    co       = (c1_r != 4'd0) ? c1_r : c2_r;
    if ((co & (OcBottom | OcTop)) != 4'd0) begin
      bo = x1_r;  eo = x2_r;  bc = y1_r;  ec = y2_r;
      edge_sel = ((co & OcBottom) != 4'd0) ? {1'b0, win.bottom_edge} : {1'b0, win.top_edge};
    end else begin
      bo = y1_r;  eo = y2_r;  bc = x1_r;  ec = x2_r;
      edge_sel = ((co & OcRight) != 4'd0) ? win.right_edge : win.left_edge;
    end
    mag_d  = delta_r[W-1] ? W'(-delta_r) : W'(delta_r);
    mag_n  = num_r[W-1] ? W'(-num_r) : W'(num_r);
    prod   = mag_d * mag_n;
    trial  = {rem_r, dq_r[W-1]} - {1'b0, divisor_r};
    q      = dz_r ? '0 : dq_r;
    interp = neg_r ? (W'(base_r) - $signed(q)) : (W'(base_r) + $signed(q));
    edge_c = $signed(C'(edge_r));
    if (ysel_r) begin
      ny = edge_c;  nx = interp[C-1:0];
    end else begin
      nx = edge_c;  ny = interp[C-1:0];
    end
    nc = outcode($signed({{ExtBits{nx[C-1]}}, nx}), $signed({{ExtBits{ny[C-1]}}, ny}), win);
  end

  always_comb begin
    state_nxt = state_r;
    x1_nxt = x1_r;  y1_nxt = y1_r;  x2_nxt = x2_r;  y2_nxt = y2_r;
    c1_nxt = c1_r;  c2_nxt = c2_r;  pass_nxt = pass_r;
    first_nxt = first_r;  ysel_nxt = ysel_r;  edge_nxt = edge_r;  base_nxt = base_r;
    delta_nxt = delta_r;  num_nxt = num_r;  den_nxt = den_r;
    divisor_nxt = divisor_r;  rem_nxt = rem_r;  dq_nxt = dq_r;
    neg_nxt = neg_r;  dz_nxt = dz_r;  cnt_nxt = cnt_r;
    ov_nxt = 1'b0;  rej_nxt = rej_r;
    ox1_nxt = ox1_r;  oy1_nxt = oy1_r;  ox2_nxt = ox2_r;  oy2_nxt = oy2_r;
    pop = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          x1_nxt = q_head[C-1:0];
          y1_nxt = q_head[2*C-1:C];
          x2_nxt = q_head[3*C-1:2*C];
          y2_nxt = q_head[4*C-1:3*C];
          c1_nxt = q_head[4*C+3:4*C];
          c2_nxt = q_head[4*C+7:4*C+4];
          pass_nxt = '0;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if ((c1_r | c2_r) == 4'd0) begin
          ov_nxt = 1'b1;  rej_nxt = 1'b0;
          ox1_nxt = x1_r;  oy1_nxt = y1_r;  ox2_nxt = x2_r;  oy2_nxt = y2_r;
          state_nxt = ST_IDLE;
        end else if ((c1_r & c2_r) != 4'd0 || pass_r >= PassBits'(MAX_PASSES)) begin
          ov_nxt = 1'b1;  rej_nxt = 1'b1;
          ox1_nxt = '1;  oy1_nxt = '1;  ox2_nxt = '1;  oy2_nxt = '1;
          state_nxt = ST_IDLE;
        end else begin
          first_nxt = (c1_r != 4'd0);
          ysel_nxt  = ((co & (OcBottom | OcTop)) != 4'd0);
          edge_nxt  = edge_sel;
          base_nxt  = bo;
          delta_nxt = W'(eo) - W'(bo);
          num_nxt   = $signed(W'(edge_sel)) - W'(bc);
          den_nxt   = W'(ec) - W'(bc);
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        rem_nxt     = prod[2*W-1:W];
        dq_nxt      = prod[W-1:0];
        divisor_nxt = den_r[W-1] ? W'(-den_r) : W'(den_r);
        neg_nxt     = delta_r[W-1] ^ num_r[W-1] ^ den_r[W-1];
        dz_nxt      = (den_r == '0);
        cnt_nxt     = '0;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        if (!trial[W]) begin
          rem_nxt = trial[W-1:0];
          dq_nxt  = {dq_r[W-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[W-2:0], dq_r[W-1]};
          dq_nxt  = {dq_r[W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CntBits'(W - 1)) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (first_r) begin
          x1_nxt = nx;  y1_nxt = ny;  c1_nxt = nc;
        end else begin
          x2_nxt = nx;  y2_nxt = ny;  c2_nxt = nc;
        end
        pass_nxt  = pass_r + 1'b1;
        state_nxt = ST_CHECK;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- design/line_clip_to_window_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Line clip to window
// Cohen-Sutherland clipping of one 2-D segment against a programmable window.
// ----------------------------------------------------------------------------
// A segment is taken when start is high and busy is low. Each transaction
// yields exactly one result, shown for a single cycle with out_valid high; the
// receiver cannot stall, so it must capture the result in that cycle. A front
// stage computes the endpoint outcodes and feeds a two-entry queue, so up to
// three segments can be waiting while the clip engine works. The engine fetches
// a segment from the queue and checks its outcodes, which settles a trivially
// accepted or rejected segment. Otherwise it makes edge passes, each with
// operand setup, one multiply, a restoring divide that yields one of its
// COORD_BITS + 1 quotient bits per cycle, and the update. At most MAX_PASSES
// passes are made before a segment is rejected.
// Rejected segments come out with all coordinates at -1 and out_rejected set.
// Window registers are written through cfg_we, cfg_index and cfg_wdata and
// should only change while no transaction is in flight.
module line_clip_to_window_top import clw_pkg::*; #(
  parameter int MAX_PASSES = MaxPassesDef,
  parameter int COORD_BITS = CoordBitsDef
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output      logic                   busy,
  input  wire logic [COORD_BITS-1:0]  in_first_x,
  input  wire logic [COORD_BITS-1:0]  in_first_y,
  input  wire logic [COORD_BITS-1:0]  in_second_x,
  input  wire logic [COORD_BITS-1:0]  in_second_y,
  output      logic                   out_valid,
  output      logic [COORD_BITS-1:0]  out_clipped_first_x,
  output      logic [COORD_BITS-1:0]  out_clipped_first_y,
  output      logic [COORD_BITS-1:0]  out_clipped_second_x,
  output      logic [COORD_BITS-1:0]  out_clipped_second_y,
  output      logic                   out_rejected,
  input  wire logic                   cfg_we,
  input  wire logic [CfgIdxBits-1:0]  cfg_index,
  input  wire logic [CfgDataBits-1:0] cfg_wdata
);
  localparam int QWidth = 4 * COORD_BITS + 8;

  window_t           win_r;
  logic              push, q_full, q_empty, pop;
  logic [QWidth-1:0] push_data, q_head;

  // Window registers. Reset values give a 30..290 by 30..190 window.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.left_edge   <= 9'd30;
      win_r.right_edge  <= 9'd290;
      win_r.top_edge    <= 8'd30;
      win_r.bottom_edge <= 8'd190;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgLeft:   win_r.left_edge   <= cfg_wdata;
        CfgRight:  win_r.right_edge  <= cfg_wdata;
        CfgTop:    win_r.top_edge    <= cfg_wdata[7:0];
        CfgBottom: win_r.bottom_edge <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  clw_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst_n, .start, .busy,
    .in_first_x, .in_first_y, .in_second_x, .in_second_y,
    .win(win_r), .push, .push_data, .q_full
  );

  clw_queue #(.WIDTH(QWidth), .DEPTH(2)) u_queue (
    .clk, .rst_n, .push, .push_data, .full(q_full),
    .pop, .head_data(q_head), .empty(q_empty)
  );

  clw_clip #(.COORD_BITS(COORD_BITS), .MAX_PASSES(MAX_PASSES)) u_clip (
    .clk, .rst_n, .win(win_r), .q_empty, .q_head, .pop,
    .out_valid, .out_clipped_first_x, .out_clipped_first_y,
    .out_clipped_second_x, .out_clipped_second_y, .out_rejected
  );

endmodule
`default_nettype wire

// ----- bench/line_clip_to_window_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line clip to window testbench
// Sends segments through the start/busy port, predicts every clipped result
// with an independent outcode clipper and checks each out_valid strobe
// against it, field by field, over several window settings.
// ----------------------------------------------------------------------------
module line_clip_to_window_top_test;
  import clw_pkg::*;

  localparam int CB         = 16;
  localparam int PASS_LIMIT = 8;
  localparam int STALL_MAX  = 5000;

  typedef struct packed {
    logic signed [CB-1:0] ax;
    logic signed [CB-1:0] ay;
    logic signed [CB-1:0] bx;
    logic signed [CB-1:0] by;
  } segment_t;

  typedef struct packed {
    logic [CB-1:0] ax;
    logic [CB-1:0] ay;
    logic [CB-1:0] bx;
    logic [CB-1:0] by;
    logic          rej;
  } clipped_t;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [CB-1:0]          in_first_x, in_first_y, in_second_x, in_second_y;
  logic                   out_valid;
  logic [CB-1:0]          out_clipped_first_x, out_clipped_first_y;
  logic [CB-1:0]          out_clipped_second_x, out_clipped_second_y;
  logic                   out_rejected;
  logic                   cfg_we;
  logic [CfgIdxBits-1:0]  cfg_index;
  logic [CfgDataBits-1:0] cfg_wdata;

  line_clip_to_window_top #(.MAX_PASSES(PASS_LIMIT), .COORD_BITS(CB)) u_dut (
    .clk, .rst_n, .start, .busy,
    .in_first_x, .in_first_y, .in_second_x, .in_second_y,
    .out_valid, .out_clipped_first_x, .out_clipped_first_y,
    .out_clipped_second_x, .out_clipped_second_y, .out_rejected,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  // The clock runs at 4 ns: 2 ns high, 2 ns low.
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Segments waiting to be sent, and the clipped results still owed.
  segment_t segments_to_send[$];
  clipped_t clips_owed[$];
  window_t  win;
  bit       no_gaps;
  bit       took_segment;
  int       errors, segs_sent, clips_seen, rejects_seen, stall_cycles;

  // Interpolated coordinate: base + delta * (edge - base_c) / (end_c - base_c),
  // rounded toward zero. A zero divisor keeps the base coordinate.
  function automatic longint interp(longint bo, longint eo, longint bc, longint ec,
                                    longint edge_at);
    longint num, den, delta, q;
    bit neg;
    num   = edge_at - bc;
    den   = ec - bc;
    delta = eo - bo;
    if (den == 0) return bo;
    neg = ((delta < 0) != (num < 0)) != (den < 0);
    q = ((delta < 0 ? -delta : delta) * (num < 0 ? -num : num)) / (den < 0 ? -den : den);
    return neg ? bo - q : bo + q;
  endfunction

  function automatic logic [3:0] region(longint x, longint y, window_t w);
    logic [3:0] c;
    c = 4'd0;
    if (x < longint'(w.left_edge))   c |= OcLeft;
    if (x > longint'(w.right_edge))  c |= OcRight;
    if (y < longint'(w.top_edge))    c |= OcTop;
    if (y > longint'(w.bottom_edge)) c |= OcBottom;
    return c;
  endfunction

  function automatic clipped_t clip_segment(segment_t s, window_t w);
    longint     x1, y1, x2, y2, nx, ny;
    logic [3:0] c1, c2, co;
    bit         rej;
    clipped_t   r;
    x1 = s.ax; y1 = s.ay; x2 = s.bx; y2 = s.by;
    c1 = region(x1, y1, w);
    c2 = region(x2, y2, w);
    rej = 1'b0;
    for (int pass = 0; ; pass++) begin
      if ((c1 | c2) == 4'd0) break;
      if ((c1 & c2) != 4'd0 || pass >= PASS_LIMIT) begin
        rej = 1'b1;
        break;
      end
      co = (c1 != 4'd0) ? c1 : c2;
      if (co & OcBottom) begin
        ny = w.bottom_edge;
        nx = interp(x1, x2, y1, y2, ny);
      end else if (co & OcTop) begin
        ny = w.top_edge;
        nx = interp(x1, x2, y1, y2, ny);
      end else if (co & OcRight) begin
        nx = w.right_edge;
        ny = interp(y1, y2, x1, x2, nx);
      end else begin
        nx = w.left_edge;
        ny = interp(y1, y2, x1, x2, nx);
      end
      if (co == c1) begin
        x1 = nx; y1 = ny; c1 = region(x1, y1, w);
      end else begin
        x2 = nx; y2 = ny; c2 = region(x2, y2, w);
      end
    end
    if (rej) begin
      x1 = -1; y1 = -1; x2 = -1; y2 = -1;
    end
    r.ax = x1[CB-1:0]; r.ay = y1[CB-1:0];
    r.bx = x2[CB-1:0]; r.by = y2[CB-1:0];
    r.rej = rej;
    return r;
  endfunction

  // Driver: the next segment is presented at the falling edge once the
  // previous transaction has been taken, with random gaps unless a phase
  // runs without them.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took_segment) begin
      if (segments_to_send.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 16)) begin
        segment_t s;
        s = segments_to_send.pop_front();
        start       <= 1'b1;
        in_first_x  <= s.ax;
        in_first_y  <= s.ay;
        in_second_x <= s.bx;
        in_second_y <= s.by;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: a transaction is taken at a rising edge with start high and busy
  // low; its expected result is predicted then. Each strobed result is
  // checked against the oldest prediction.
  always @(posedge clk) begin
    clipped_t got, want;
    took_segment = rst_n && start && !busy;
    if (took_segment) begin
      clips_owed.push_back(clip_segment({in_first_x, in_first_y, in_second_x, in_second_y},
                                        win));
      segs_sent++;
    end
    if (rst_n && out_valid) begin
      got = {out_clipped_first_x, out_clipped_first_y, out_clipped_second_x,
             out_clipped_second_y, out_rejected};
      clips_seen++;
      if (out_rejected) rejects_seen++;
      if (clips_owed.size() == 0) begin
        $display("%0t: result with none owed: %h", $time, got);
        errors++;
      end else begin
        want = clips_owed.pop_front();
        if (got.ax !== want.ax)
          $display("%0t: first_x expected %0d got %0d", $time, $signed(want.ax), $signed(got.ax));
        if (got.ay !== want.ay)
          $display("%0t: first_y expected %0d got %0d", $time, $signed(want.ay), $signed(got.ay));
        if (got.bx !== want.bx)
          $display("%0t: second_x expected %0d got %0d", $time, $signed(want.bx),
                   $signed(got.bx));
        if (got.by !== want.by)
          $display("%0t: second_y expected %0d got %0d", $time, $signed(want.by),
                   $signed(got.by));
        if (got.rej !== want.rej)
          $display("%0t: rejected expected %0b got %0b", $time, want.rej, got.rej);
        if (got !== want) errors++;
      end
    end
    // Watchdog: count cycles in which nothing moves through either port.
    if (took_segment || out_valid || !rst_n) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles > STALL_MAX) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_MAX);
      $display("FAIL line_clip_to_window_top");
      $finish;
    end
  end

  function automatic logic signed [CB-1:0] pick_coord();
    // Mostly near the window so clipping passes happen; sometimes anything.
    if ($urandom_range(0, 9) < 2) return CB'($urandom);
    return CB'(int'($urandom_range(0, 460)) - 80);
  endfunction

  task automatic add_seg(int ax, int ay, int bx, int by);
    segment_t s;
    s.ax = CB'(ax); s.ay = CB'(ay); s.bx = CB'(bx); s.by = CB'(by);
    segments_to_send.push_back(s);
  endtask

  task automatic add_random(int n);
    segment_t s;
    repeat (n) begin
      s.ax = pick_coord(); s.ay = pick_coord();
      s.bx = pick_coord(); s.by = pick_coord();
      segments_to_send.push_back(s);
    end
  endtask

  // Let the block drain completely so a window write cannot hit a transaction.
  task automatic drain();
    while (segments_to_send.size() > 0 || clips_owed.size() > 0 || start)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_edge(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgLeft:   win.left_edge   = val;
      CfgRight:  win.right_edge  = val;
      CfgTop:    win.top_edge    = val[7:0];
      CfgBottom: win.bottom_edge = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_window(int l, int r, int t, int b);
    write_edge(CfgLeft, CfgDataBits'(l));
    write_edge(CfgRight, CfgDataBits'(r));
    write_edge(CfgTop, CfgDataBits'(t));
    write_edge(CfgBottom, CfgDataBits'(b));
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CfgLeft;
    cfg_wdata = '0;
    in_first_x = '0; in_first_y = '0; in_second_x = '0; in_second_y = '0;
    win = '{left_edge: 9'd30, right_edge: 9'd290, top_edge: 8'd30, bottom_edge: 8'd190};
    no_gaps = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed segments against the reset window (30..290 by 30..190).
    add_seg(100, 100, 200, 150);            // wholly inside, passes unchanged
    add_seg(30, 30, 290, 190);              // exactly on the corners
    add_seg(0, 50, 10, 150);                // both left: rejected
    add_seg(300, 50, 400, 150);             // both right
    add_seg(50, 0, 150, 20);                // both above
    add_seg(50, 200, 150, 230);             // both below
    add_seg(0, 100, 320, 100);              // crosses left and right edges
    add_seg(100, 0, 100, 239);              // crosses top and bottom edges
    add_seg(0, 0, 319, 239);                // diagonal, clipped at the top and bottom edges
    add_seg(319, 239, 0, 0);                // the same, reversed
    add_seg(150, 100, 150, 300);            // second endpoint moved to bottom
    add_seg(0, 200, 60, 0);                 // crosses the left and top edges
    add_seg(-32768, -32768, 32767, 32767);  // coordinate extremes
    add_seg(32767, -32768, -32768, 32767);
    add_seg(-32768, 100, 32767, 100);
    add_seg(-1, -1, -1, -1);                // zero length, outside
    add_seg(120, 120, 120, 120);            // zero length, inside
    add_seg(32767, 32767, 32767, 32767);
    add_seg(-32768, 100, 100, 100);         // left crossing from far away
    add_seg(100, -32768, 101, 32767);       // steep, nearly vertical
    drain();

    add_random(180);
    drain();

    // Full screen, sent back to back without gaps.
    no_gaps = 1'b1;
    set_window(0, 319, 0, 239);
    add_random(120);
    drain();
    no_gaps = 1'b0;

    // Inverted window: nothing is inside, so every segment is rejected, trivially or once the pass budget runs out.
    set_window(319, 0, 239, 0);
    add_random(80);
    drain();

    // A single point window at the origin.
    set_window(0, 0, 0, 0);
    add_random(50);
    drain();

    // Registers at the top of their width, beyond the nominal range.
    set_window(511, 511, 255, 255);
    add_seg(0, 0, 600, 300);
    add_random(60);
    drain();

    // A few random windows, which may come out inverted.
    repeat (4) begin
      set_window($urandom_range(0, 511), $urandom_range(0, 511),
                 $urandom_range(0, 255), $urandom_range(0, 255));
      add_random(40);
      drain();
    end

    $display("Sent %0d segments over nine window settings; %0d results checked, %0d rejected.",
             segs_sent, clips_seen, rejects_seen);
    $display("Windows covered reset, full screen, inverted, single point and maximum edges.");
    if (errors == 0) begin
      $display("PASS line_clip_to_window_top");
    end else begin
      $display("FAIL line_clip_to_window_top");
    end
    $finish;
  end

endmodule

// ----- line_clip_to_window_top.f -----
design/clw_pkg.sv
design/clw_queue.sv
design/clw_front.sv
design/clw_clip.sv
design/line_clip_to_window_top.sv
bench/line_clip_to_window_top_test.sv
